### rtl/cache_prefetch_address_generator_assert.svh
// Assertion macros for the prefetch address generator.
// CPAG_ASSERT checks a property on every edge outside reset.
// CPAG_ASSERT_ALWAYS checks a property on every edge, reset included.
`ifndef CACHE_PREFETCH_ADDRESS_GENERATOR_ASSERT_SVH
`define CACHE_PREFETCH_ADDRESS_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define CPAG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CPAG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPAG_ASSERT(label, clk, rst, prop, msg)
`define CPAG_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/cpag_pkg.sv
package cpag_pkg;

   // prefetcher selection
   typedef enum logic [1:0] {
      MODE_NONE        = 2'd0,
      MODE_ADJACENT    = 2'd1,
      MODE_SEQUENTIAL  = 2'd2,
      MODE_BEST_EFFORT = 2'd3
   } mode_type;

   // demand event kinds
   localparam logic CMD_MISS = 1'b0;
   localparam logic CMD_HIT  = 1'b1;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQ_DEGREE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MISS_SPAN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIT_SPAN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAG_BITS   = 3'd5;

   localparam int ADDR_W   = 64;
   localparam int THREAD_W = 8;
   localparam int SPAN_REG_W = 5;

   // job fields sized for the largest supported span (32): up to 62 addresses
   localparam int JOB_COUNT_W = 6;
   localparam int JOB_BACK_W  = 5;

   typedef struct packed {
      mode_type                mode;
      logic [SPAN_REG_W-1:0]   seq_degree;
      logic [SPAN_REG_W-1:0]   miss_span;
      logic [SPAN_REG_W-1:0]   hit_span;
      logic [ADDR_W-1:0]       set_bits;
      logic [ADDR_W-1:0]       tag_bits;
   } cfg_type;

   // one run of prefetch addresses handed from front to back
   typedef struct packed {
      logic [ADDR_W-1:0]      address;
      logic [THREAD_W-1:0]    thread;
      logic [JOB_COUNT_W-1:0] count;
      logic [JOB_BACK_W-1:0]  back;
   } job_type;

endpackage

### rtl/cache_prefetch_address_generator.sv
// The first prefetch address of a request passes the job queue, the walker registers and
// the output register; the rest of its run follows at one address per cycle while rsp_stall
// is low (up to 2*MAX_SPAN-2 per request, 30 with the default MAX_SPAN).
// Throughput: one request per cycle while the two-entry job queue has room; the address
// walker in the back end, one address per cycle while rsp_stall is low, sets the sustained rate.
// Reset: synchronous; registers return to defaults, stream state to zero, queue and output empty.
`include "cache_prefetch_address_generator_assert.svh"

module cache_prefetch_address_generator #(
   parameter int BLOCK_BYTES = 64,
   parameter int MAX_SPAN    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [cpag_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cpag_pkg::ADDR_W-1:0]          csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [cpag_pkg::ADDR_W-1:0]          req_access_address,
   input  logic [cpag_pkg::THREAD_W-1:0]        req_thread_id,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cpag_pkg::ADDR_W-1:0]          rsp_prefetch_address,
   output logic [cpag_pkg::THREAD_W-1:0]        rsp_prefetch_thread,
   output logic                                 rsp_last
);

   cpag_pkg::cfg_type cfg_ff, cfg_in;
   logic              q_push;
   cpag_pkg::job_type q_push_job;
   logic              q_pop;
   logic              q_full;
   logic              q_valid;
   cpag_pkg::job_type q_job;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cpag_pkg::CSR_MODE:       cfg_in.mode = cpag_pkg::mode_type'(csr_write_data[1:0]);
            cpag_pkg::CSR_SEQ_DEGREE: cfg_in.seq_degree = csr_write_data[cpag_pkg::SPAN_REG_W-1:0];
            cpag_pkg::CSR_MISS_SPAN:  cfg_in.miss_span = csr_write_data[cpag_pkg::SPAN_REG_W-1:0];
            cpag_pkg::CSR_HIT_SPAN:   cfg_in.hit_span = csr_write_data[cpag_pkg::SPAN_REG_W-1:0];
            cpag_pkg::CSR_SET_BITS:   cfg_in.set_bits = csr_write_data;
            cpag_pkg::CSR_TAG_BITS:   cfg_in.tag_bits = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= cpag_pkg::MODE_NONE;
         cfg_ff.seq_degree <= cpag_pkg::SPAN_REG_W'(1);
         cfg_ff.miss_span  <= cpag_pkg::SPAN_REG_W'(2);
         cfg_ff.hit_span   <= cpag_pkg::SPAN_REG_W'(3);
         cfg_ff.set_bits   <= 64'h0000_0000_0000_0FC0;
         cfg_ff.tag_bits   <= 64'hFFFF_FFFF_FFFF_F000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;

   cpag_front #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .MAX_SPAN    (MAX_SPAN)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_stall          (q_full),
      .req_command        (req_command),
      .req_access_address (req_access_address),
      .req_thread_id      (req_thread_id),
      .push               (q_push),
      .job                (q_push_job)
   );

   cpag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .pop       (q_pop),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_job   (q_job)
   );

   cpag_back #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .job_valid            (q_valid),
      .job                  (q_job),
      .job_pop              (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_prefetch_address (rsp_prefetch_address),
      .rsp_prefetch_thread  (rsp_prefetch_thread),
      .rsp_last             (rsp_last)
   );

   // checks
   `CPAG_ASSERT(a_no_push_when_full, clock, reset, q_push |-> !q_full, "job pushed into full queue")
   `CPAG_ASSERT(a_none_mode_quiet, clock, reset, (req_valid && !req_stall && (cfg_ff.mode == cpag_pkg::MODE_NONE)) |-> !q_push, "null mode produced a run")
   `CPAG_ASSERT(a_adjacent_single, clock, reset, (q_push && (cfg_ff.mode == cpag_pkg::MODE_ADJACENT)) |-> (q_push_job.count == cpag_pkg::JOB_COUNT_W'(1)), "adjacent run longer than one")
   `CPAG_ASSERT_ALWAYS(a_empty_after_reset, clock, ($past(reset) && !reset) |-> (!rsp_valid && !q_valid), "output or queue not empty after reset")

endmodule

### rtl/cpag_front.sv
module cpag_front #(
   parameter int BLOCK_BYTES = 64,
   parameter int MAX_SPAN    = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cpag_pkg::cfg_type           cfg,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_command,
   input  logic [cpag_pkg::ADDR_W-1:0] req_access_address,
   input  logic [cpag_pkg::THREAD_W-1:0] req_thread_id,
   output logic                        push,
   output cpag_pkg::job_type           job
);

   localparam int SPAN_W = $clog2(MAX_SPAN + 1);
   localparam int CNT_W  = $clog2(2 * MAX_SPAN + 1);
   localparam int BLK_W  = $clog2(BLOCK_BYTES + 1);
   localparam int OFF_W  = BLK_W + SPAN_W;
   localparam logic [cpag_pkg::ADDR_W-1:0] BLK = cpag_pkg::ADDR_W'(BLOCK_BYTES);

   logic [cpag_pkg::ADDR_W-1:0] prev_miss_set_ff, prev_miss_set_in;
   logic [cpag_pkg::ADDR_W-1:0] prev_miss_tag_ff, prev_miss_tag_in;
   logic [cpag_pkg::ADDR_W-1:0] stream_address_ff, stream_address_in;
   logic [cpag_pkg::ADDR_W-1:0] stream_set_ff, stream_set_in;
   logic [cpag_pkg::ADDR_W-1:0] stream_tag_ff, stream_tag_in;

   logic                        accept;
   logic                        is_hit;
   logic [cpag_pkg::ADDR_W-1:0] my_set;
   logic [cpag_pkg::ADDR_W-1:0] my_tag;
   logic                        miss_match;
   logic                        hit_match;
   logic [SPAN_W-1:0]           degree;
   logic [SPAN_W-1:0]           span;
   logic [SPAN_W-1:0]           back;
   logic [SPAN_W-1:0]           mult_k;
   logic                        subtract;
   logic [CNT_W-1:0]            count;
   logic [SPAN_W-1:0]           back_n;
   logic [OFF_W-1:0]            offset;
   logic [cpag_pkg::ADDR_W-1:0] start;
   logic [cpag_pkg::ADDR_W-1:0] new_stream;

   assign accept = req_valid && !req_stall;
   assign is_hit = (req_command == cpag_pkg::CMD_HIT);
   assign my_set = req_access_address & cfg.set_bits;
   assign my_tag = req_access_address & cfg.tag_bits;

   // sequential stream matches
   assign miss_match = (my_tag == prev_miss_tag_ff) && (my_set == prev_miss_set_ff + BLK);
   assign hit_match  = (my_tag == stream_tag_ff) && (my_set == stream_set_ff);

   // clamp degree to 1..MAX_SPAN and span to 0..MAX_SPAN
   always_comb begin
      if (cfg.seq_degree == '0) begin
         degree = SPAN_W'(1);
      end else if (int'(cfg.seq_degree) > MAX_SPAN) begin
         degree = SPAN_W'(MAX_SPAN);
      end else begin
         degree = SPAN_W'(cfg.seq_degree);
      end
   end

   always_comb begin
      if (is_hit) begin
         if (int'(cfg.hit_span) > MAX_SPAN) begin
            span = SPAN_W'(MAX_SPAN);
         end else begin
            span = SPAN_W'(cfg.hit_span);
         end
         back = (int'(span) > 3) ? span - SPAN_W'(3) : '0;
      end else begin
         if (int'(cfg.miss_span) > MAX_SPAN) begin
            span = SPAN_W'(MAX_SPAN);
         end else begin
            span = SPAN_W'(cfg.miss_span);
         end
         back = (int'(span) > 2) ? span - SPAN_W'(2) : '0;
      end
   end

   // classify the event into a run: first address, length, backward part
   always_comb begin
      mult_k   = SPAN_W'(1);
      subtract = 1'b0;
      count    = '0;
      back_n   = '0;
      case (cfg.mode)
         cpag_pkg::MODE_ADJACENT: begin
            count = CNT_W'(1);
         end
         cpag_pkg::MODE_SEQUENTIAL: begin
            if (!is_hit) begin
               if (miss_match) begin
                  count = CNT_W'(degree);
               end
            end else if (hit_match) begin
               count  = CNT_W'(1);
               mult_k = degree;
            end
         end
         cpag_pkg::MODE_BEST_EFFORT: begin
            count  = CNT_W'(back) + CNT_W'(span);
            back_n = back;
            if (back != '0) begin
               mult_k   = back;
               subtract = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign offset = OFF_W'(BLOCK_BYTES) * OFF_W'(mult_k);
   assign start  = subtract ? req_access_address - cpag_pkg::ADDR_W'(offset)
                            : req_access_address + cpag_pkg::ADDR_W'(offset);

   assign push          = accept && (count != '0);
   assign job.address   = start;
   assign job.thread    = req_thread_id;
   assign job.count     = cpag_pkg::JOB_COUNT_W'(count);
   assign job.back      = cpag_pkg::JOB_BACK_W'(back_n);

   // sequential state, touched only by events in sequential mode
   assign new_stream = is_hit ? stream_address_ff + BLK : req_access_address + BLK;

   always_comb begin
      prev_miss_set_in  = prev_miss_set_ff;
      prev_miss_tag_in  = prev_miss_tag_ff;
      stream_address_in = stream_address_ff;
      stream_set_in     = stream_set_ff;
      stream_tag_in     = stream_tag_ff;
      if (accept && (cfg.mode == cpag_pkg::MODE_SEQUENTIAL)) begin
         if (!is_hit) begin
            prev_miss_set_in = my_set;
            prev_miss_tag_in = my_tag;
         end
         if ((!is_hit && miss_match) || (is_hit && hit_match)) begin
            stream_address_in = new_stream;
            stream_set_in     = new_stream & cfg.set_bits;
            stream_tag_in     = new_stream & cfg.tag_bits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_miss_set_ff  <= '0;
         prev_miss_tag_ff  <= '0;
         stream_address_ff <= '0;
         stream_set_ff     <= '0;
         stream_tag_ff     <= '0;
      end else begin
         prev_miss_set_ff  <= prev_miss_set_in;
         prev_miss_tag_ff  <= prev_miss_tag_in;
         stream_address_ff <= stream_address_in;
         stream_set_ff     <= stream_set_in;
         stream_tag_ff     <= stream_tag_in;
      end
   end

endmodule

### rtl/cpag_queue.sv
module cpag_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cpag_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              pop_valid,
   output cpag_pkg::job_type pop_job
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   cpag_pkg::job_type         slot_ff [DEPTH];
   cpag_pkg::job_type         slot_in [DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]            used_ff, used_in;
   logic                      do_push;
   logic                      do_pop;

   assign full      = (used_ff == (PTR_W+1)'(DEPTH));
   assign pop_valid = (used_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      used_in   = used_ff;
      if (do_push && !do_pop) begin
         used_in = used_ff + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         used_in = used_ff - (PTR_W+1)'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_in[i] = (do_push && (wr_ptr_ff == PTR_W'(i))) ? push_job : slot_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

endmodule

### rtl/cpag_back.sv
module cpag_back #(
   parameter int BLOCK_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  cpag_pkg::job_type             job,
   output logic                          job_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cpag_pkg::ADDR_W-1:0]   rsp_prefetch_address,
   output logic [cpag_pkg::THREAD_W-1:0] rsp_prefetch_thread,
   output logic                          rsp_last
);

   localparam logic [cpag_pkg::ADDR_W-1:0] BLK  = cpag_pkg::ADDR_W'(BLOCK_BYTES);
   localparam logic [cpag_pkg::ADDR_W-1:0] BLK2 = cpag_pkg::ADDR_W'(2 * BLOCK_BYTES);

   logic                            busy_ff, busy_in;
   logic [cpag_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [cpag_pkg::THREAD_W-1:0]   thread_ff, thread_in;
   logic [cpag_pkg::JOB_COUNT_W-1:0] remain_ff, remain_in;
   logic [cpag_pkg::JOB_BACK_W-1:0] back_ff, back_in;
   logic                            out_valid_ff, out_valid_in;
   logic [cpag_pkg::ADDR_W-1:0]     out_addr_ff, out_addr_in;
   logic [cpag_pkg::THREAD_W-1:0]   out_thread_ff, out_thread_in;
   logic                            out_last_ff, out_last_in;

   logic                            out_free;
   logic                            emit;
   logic                            done;
   logic                            load;
   logic [cpag_pkg::ADDR_W-1:0]     step;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit     = busy_ff && out_free;
   assign done     = emit && (remain_ff == cpag_pkg::JOB_COUNT_W'(1));
   assign load     = job_valid && (!busy_ff || done);
   assign job_pop  = load;

   // the last backward block jumps over the demand block itself
   assign step = (back_ff == cpag_pkg::JOB_BACK_W'(1)) ? BLK2 : BLK;

   // run walker
   always_comb begin
      busy_in   = busy_ff;
      addr_in   = addr_ff;
      thread_in = thread_ff;
      remain_in = remain_ff;
      back_in   = back_ff;
      if (load) begin
         busy_in   = 1'b1;
         addr_in   = job.address;
         thread_in = job.thread;
         remain_in = job.count;
         back_in   = job.back;
      end else if (emit) begin
         busy_in   = !done;
         addr_in   = addr_ff + step;
         remain_in = remain_ff - cpag_pkg::JOB_COUNT_W'(1);
         back_in   = (back_ff != '0) ? back_ff - cpag_pkg::JOB_BACK_W'(1) : back_ff;
      end
   end

   // output register
   always_comb begin
      out_addr_in   = out_addr_ff;
      out_thread_in = out_thread_ff;
      out_last_in   = out_last_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_addr_in   = addr_ff;
         out_thread_in = thread_ff;
         out_last_in   = (remain_ff == cpag_pkg::JOB_COUNT_W'(1));
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      thread_ff     <= thread_in;
      remain_ff     <= remain_in;
      back_ff       <= back_in;
      out_addr_ff   <= out_addr_in;
      out_thread_ff <= out_thread_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_prefetch_address = out_addr_ff;
   assign rsp_prefetch_thread  = out_thread_ff;
   assign rsp_last             = out_last_ff;

endmodule
